>>> design/rbpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbpd_pkg;

    // Fixed widths of the word fields.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned FUNC_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_DROP  = 2'd2,
        FUNC_PEEK  = 2'd3
    } rbpd_func_t;

    // Status of one operation, carried from the pointer logic to the result register.
    typedef struct packed {
        logic [COUNT_W-1:0] fill_level;
        logic               is_full;
        logic               write_dropped;
        logic               is_peek;
    } rbpd_status_t;

endpackage

`default_nettype wire

>>> design/rbpd_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rbpd_mem
    import rbpd_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned IDX_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [BYTE_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output      logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] store_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/rbpd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rbpd_ctrl
    import rbpd_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned IDX_W = 8,
    parameter int unsigned CNT_W = 9
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [BYTE_W-1:0]  write_byte,
    input  wire logic [COUNT_W-1:0] drop_count,
    input  wire logic [BYTE_W-1:0]  peek_offset,
    output      logic               mem_wr_en,
    output      logic [IDX_W-1:0]   mem_wr_addr,
    output      logic [BYTE_W-1:0]  mem_wr_data,
    output      logic [IDX_W-1:0]   mem_rd_addr,
    output      rbpd_status_t       status_next
);

    // Width for pointer sums: holds anything below twice the depth and any field value.
    localparam int unsigned PW = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    rbpd_func_t       op;
    logic             is_full_now;
    logic [BYTE_W-1:0] offset_mod;
    logic [PW-1:0]    peek_sum;
    logic [PW-1:0]    drop_sum;
    logic [PW-1:0]    drop_ext;
    logic [PW-1:0]    count_ext;
    logic [31:0]      count_next_w;
    logic             dropped;

    // Reduces an 8-bit offset modulo the depth by restoring subtraction.
    function automatic logic [BYTE_W-1:0] mod_depth(input logic [BYTE_W-1:0] v);
        int unsigned r;
        r = 32'(v);
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (r >= (DEPTH << k)) begin
                r = r - (DEPTH << k);
            end
        end
        return BYTE_W'(r);
    endfunction

    assign op          = rbpd_func_t'(func);
    assign is_full_now = (count_reg == CNT_W'(DEPTH));
    assign offset_mod  = mod_depth(peek_offset);

    // Peek address: head plus reduced offset, one conditional wrap.
    always_comb begin
        peek_sum = PW'(head_reg) + PW'(offset_mod);
        if (peek_sum >= PW'(DEPTH)) begin
            peek_sum = peek_sum - PW'(DEPTH);
        end
    end

    // Drop address: only used when the count is below the fill level.
    always_comb begin
        drop_ext  = PW'(drop_count);
        count_ext = PW'(count_reg);
        drop_sum  = PW'(head_reg) + drop_ext;
        if (drop_sum >= PW'(DEPTH)) begin
            drop_sum = drop_sum - PW'(DEPTH);
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        dropped    = 1'b0;
        mem_wr_en  = 1'b0;
        if (accept) begin
            unique case (op)
                FUNC_CLEAR: begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                FUNC_WRITE: begin
                    if (is_full_now) begin
                        dropped = 1'b1;
                    end else begin
                        mem_wr_en  = 1'b1;
                        tail_next  = (tail_reg == IDX_W'(DEPTH - 1)) ? '0
                                                                     : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_DROP: begin
                    if (drop_ext >= count_ext) begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end else begin
                        head_next  = drop_sum[IDX_W-1:0];
                        count_next = CNT_W'(count_ext - drop_ext);
                    end
                end
                FUNC_PEEK: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign mem_wr_addr = tail_reg;
    assign mem_wr_data = write_byte;
    assign mem_rd_addr = peek_sum[IDX_W-1:0];

    assign count_next_w              = 32'(count_next);
    assign status_next.fill_level    = count_next_w[COUNT_W-1:0];
    assign status_next.is_full       = (count_next == CNT_W'(DEPTH));
    assign status_next.write_dropped = dropped;
    assign status_next.is_peek       = (op == FUNC_PEEK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // The fill count never goes past the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // An empty buffer has both pointers at the same place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty buffer with head and tail apart");

    // A refused write leaves the fill count and the tail alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == FUNC_WRITE && is_full_now)
        |=> ($stable(count_reg) && $stable(tail_reg)))
        else $error("refused write changed the buffer");

endmodule

`default_nettype wire

>>> design/byte_ring_buffer_peek_drop_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// A result word is registered and offered on the m_ side in the cycle after
// its word is accepted. Throughput: one word per cycle unless m_ready stalls;
// pointer update and memory accesses complete in the cycle of acceptance.
// Reset (aresetn, synchronous, active low) empties the buffer and the result
// register; byte storage is not cleared and holds no meaning until written.

module byte_ring_buffer_peek_drop_unit
    import rbpd_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire logic [FUNC_W-1:0]  s_func,
    input  wire logic [BYTE_W-1:0]  s_write_byte,
    input  wire logic [COUNT_W-1:0] s_drop_count,
    input  wire logic [BYTE_W-1:0]  s_peek_offset,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      logic [BYTE_W-1:0]  m_peek_byte,
    output      logic [COUNT_W-1:0] m_fill_level,
    output      logic               m_is_full,
    output      logic               m_write_dropped
);

    // Index width for the store and count width able to hold the depth itself.
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic              accept;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [BYTE_W-1:0] mem_wr_data;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data;
    rbpd_status_t      status_next;
    rbpd_status_t      status_reg;
    logic              valid_reg, valid_next;

    // A new word enters whenever the result register is empty or is being
    // drained in this same cycle, so back-to-back words flow without a gap.
    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    rbpd_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .func        (s_func),
        .write_byte  (s_write_byte),
        .drop_count  (s_drop_count),
        .peek_offset (s_peek_offset),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .status_next (status_next)
    );

    // The store reads only on acceptance, so its registered read data
    // stays put for as long as the result word is stalled.
    rbpd_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // The status payload needs no reset; only the valid flag is cleared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

    // Only a peek shows the stored byte; every other operation reports zero.
    assign m_valid         = valid_reg;
    assign m_peek_byte     = status_reg.is_peek ? mem_rd_data : '0;
    assign m_fill_level    = status_reg.fill_level;
    assign m_is_full       = status_reg.is_full;
    assign m_write_dropped = status_reg.write_dropped;

    // A stalled result word blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while result word is stalled");

    // A dropped write is only ever reported on a word that is not full-free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg.write_dropped) |-> status_reg.is_full)
        else $error("write reported dropped while buffer not full");

    // A result word, once offered, stays offered until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |=> valid_reg)
        else $error("result word withdrawn before it was taken");

endmodule

`default_nettype wire

>>> verif/byte_ring_buffer_peek_drop_unit_tb.sv
`timescale 1ns / 1ps

module byte_ring_buffer_peek_drop_unit_tb;

    import rbpd_pkg::*;

    localparam int unsigned DEPTH       = 256;
    // Cycles without any accepted word before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 2000;
    // Cycles to wait after the last expected word so that any extra word shows up.
    localparam int unsigned TAIL_CYCLES = 4;

    // One result word as the block presents it on the m_ side.
    typedef struct packed {
        logic [BYTE_W-1:0]  peek_byte;
        logic [COUNT_W-1:0] fill_level;
        logic               is_full;
        logic               write_dropped;
    } ring_result_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic [FUNC_W-1:0]  s_func          = '0;
    logic [BYTE_W-1:0]  s_write_byte    = '0;
    logic [COUNT_W-1:0] s_drop_count    = '0;
    logic [BYTE_W-1:0]  s_peek_offset   = '0;
    logic               m_ready         = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic [BYTE_W-1:0]  m_peek_byte;
    logic [COUNT_W-1:0] m_fill_level;
    logic               m_is_full;
    logic               m_write_dropped;

    // Shadow copy of the buffer used to predict every result word. The
    // written flags keep the stimulus away from entries that hold no data yet.
    logic [BYTE_W-1:0]  shadow_bytes [DEPTH];
    bit                 shadow_written [DEPTH];
    int unsigned        shadow_head  = 0;
    int unsigned        shadow_tail  = 0;
    int unsigned        shadow_count = 0;

    // Expected result words, oldest first.
    ring_result_t       pending_results [$];

    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_idle_pct  = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        stall_cycles   = 0;

    byte_ring_buffer_peek_drop_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_write_byte   (s_write_byte),
        .s_drop_count   (s_drop_count),
        .s_peek_offset  (s_peek_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peek_byte    (m_peek_byte),
        .m_fill_level   (m_fill_level),
        .m_is_full      (m_is_full),
        .m_write_dropped(m_write_dropped)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // A clear, and a drop that reaches the fill level, both bring the
    // pointers back to zero while the stored bytes stay where they are.
    function automatic void empty_shadow();
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_count = 0;
    endfunction

    // Applies one accepted operation to the shadow buffer and returns the
    // result word the block must produce for it.
    function automatic ring_result_t predict_result(input rbpd_func_t func,
                                                    input logic [BYTE_W-1:0] wr_byte,
                                                    input logic [COUNT_W-1:0] drop_cnt,
                                                    input logic [BYTE_W-1:0] peek_off);
        ring_result_t res;
        res = '0;
        case (func)
            FUNC_CLEAR: begin
                empty_shadow();
            end
            FUNC_WRITE: begin
                if (shadow_count >= DEPTH) begin
                    res.write_dropped = 1'b1;
                end else begin
                    shadow_bytes[shadow_tail]   = wr_byte;
                    shadow_written[shadow_tail] = 1'b1;
                    shadow_tail                 = (shadow_tail + 1) % DEPTH;
                    shadow_count++;
                end
            end
            FUNC_DROP: begin
                if (drop_cnt >= shadow_count) begin
                    empty_shadow();
                end else begin
                    shadow_head  = (shadow_head + drop_cnt) % DEPTH;
                    shadow_count = shadow_count - drop_cnt;
                end
            end
            default: begin
                res.peek_byte = shadow_bytes[(shadow_head + peek_off) % DEPTH];
            end
        endcase
        res.fill_level = COUNT_W'(shadow_count);
        res.is_full    = (shadow_count == DEPTH);
        return res;
    endfunction

    // Presents one operation word, holding it until the block takes it. The
    // sender may idle first; valid is only lowered when it really idles, so it
    // never gets two assignments in one time step.
    task automatic send_word(input rbpd_func_t func,
                             input logic [BYTE_W-1:0] wr_byte,
                             input logic [COUNT_W-1:0] drop_cnt,
                             input logic [BYTE_W-1:0] peek_off);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_write_byte  <= wr_byte;
        s_drop_count  <= drop_cnt;
        s_peek_offset <= peek_off;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_results.push_back(predict_result(func, wr_byte, drop_cnt, peek_off));
    endtask

    // Holds the sender off until every expected word has come back. It waits for
    // an edge before checking, so that valid is not lowered and raised in one step.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Empty-buffer operations, basic writes and peeks, peeks past the fill
    // level into stale data, drops of zero, of exactly the fill level and of
    // the full depth, and a clear that keeps the stored bytes.
    task automatic test_directed_ops();
        send_word(FUNC_DROP,  8'h00, 9'd0,   8'h00);
        send_word(FUNC_DROP,  8'hFF, 9'd256, 8'hFF);
        send_word(FUNC_CLEAR, 8'h55, 9'd511, 8'hAA);
        send_word(FUNC_WRITE, 8'h00, 9'd0,   8'h00);
        send_word(FUNC_WRITE, 8'hFF, 9'd0,   8'h00);
        send_word(FUNC_WRITE, 8'hA5, 9'd0,   8'h00);
        send_word(FUNC_WRITE, 8'h5A, 9'd0,   8'h00);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd0);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd3);
        send_word(FUNC_DROP,  8'h00, 9'd0,   8'h00);
        send_word(FUNC_DROP,  8'h00, 9'd2,   8'h00);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd0);
        // These two offsets wrap around to bytes that sit behind the head.
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd255);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd254);
        send_word(FUNC_DROP,  8'h00, 9'd2,   8'h00);
        send_word(FUNC_WRITE, 8'h3C, 9'd0,   8'h00);
        send_word(FUNC_WRITE, 8'hC3, 9'd0,   8'h00);
        send_word(FUNC_CLEAR, 8'h00, 9'd0,   8'h00);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd1);
        send_word(FUNC_WRITE, 8'h81, 9'd0,   8'h00);
        send_word(FUNC_DROP,  8'h00, 9'd1,   8'h00);
        send_word(FUNC_WRITE, 8'h7E, 9'd0,   8'h00);
        send_word(FUNC_DROP,  8'h00, 9'd256, 8'h00);
        wait_for_results();
    endtask

    // Fills the buffer to the brim, checks that further writes are refused,
    // and wraps the tail around the end of the storage. Afterwards every
    // entry holds data, so the random traffic may peek anywhere.
    task automatic test_full_buffer();
        send_word(FUNC_CLEAR, 8'h00, 9'd0, 8'h00);
        repeat (DEPTH) begin
            send_word(FUNC_WRITE, 8'($urandom), 9'd0, 8'h00);
        end
        send_word(FUNC_WRITE, 8'hEE, 9'd0,   8'h00);
        send_word(FUNC_WRITE, 8'h11, 9'd0,   8'h00);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd0);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd255);
        send_word(FUNC_DROP,  8'h00, 9'd0,   8'h00);
        send_word(FUNC_DROP,  8'h00, 9'd1,   8'h00);
        send_word(FUNC_WRITE, 8'h99, 9'd0,   8'h00);
        send_word(FUNC_WRITE, 8'h66, 9'd0,   8'h00);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd255);
        send_word(FUNC_DROP,  8'h00, 9'd255, 8'h00);
        send_word(FUNC_PEEK,  8'h00, 9'd0,   8'd0);
        send_word(FUNC_DROP,  8'h00, 9'd256, 8'h00);
        wait_for_results();
    endtask

    // Random traffic in bursts of one flavor each: filling, draining, mixed
    // and peek-heavy. Drop counts lean toward the interesting edges around
    // the current fill level; peeks mostly land inside the held bytes.
    task automatic test_random_traffic(input int unsigned n_words,
                                       input int unsigned sender_pct,
                                       input int unsigned receiver_pct);
        int unsigned        burst_left;
        int unsigned        mode;
        int unsigned        roll;
        int unsigned        count_pick;
        rbpd_func_t         func;
        logic [COUNT_W-1:0] drop_cnt;
        logic [BYTE_W-1:0]  peek_off;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        burst_left    = 0;
        mode          = 0;
        for (int unsigned i = 0; i < n_words; i++) begin
            if (burst_left == 0) begin
                mode       = $urandom_range(3);
                burst_left = $urandom_range(300, 20);
            end
            burst_left--;
            roll = $urandom_range(99);
            case (mode)
                0: begin
                    if (roll < 80)      func = FUNC_WRITE;
                    else if (roll < 90) func = FUNC_PEEK;
                    else if (roll < 99) func = FUNC_DROP;
                    else                func = FUNC_CLEAR;
                end
                1: begin
                    if (roll < 25)      func = FUNC_WRITE;
                    else if (roll < 50) func = FUNC_PEEK;
                    else if (roll < 98) func = FUNC_DROP;
                    else                func = FUNC_CLEAR;
                end
                2: begin
                    if (roll < 40)      func = FUNC_WRITE;
                    else if (roll < 70) func = FUNC_PEEK;
                    else if (roll < 96) func = FUNC_DROP;
                    else                func = FUNC_CLEAR;
                end
                default: begin
                    if (roll < 20)      func = FUNC_WRITE;
                    else if (roll < 80) func = FUNC_PEEK;
                    else if (roll < 97) func = FUNC_DROP;
                    else                func = FUNC_CLEAR;
                end
            endcase

            case ($urandom_range(9))
                0:       count_pick = 0;
                1:       count_pick = shadow_count;
                2:       count_pick = (shadow_count < DEPTH) ? shadow_count + 1 : DEPTH;
                3:       count_pick = DEPTH;
                4:       count_pick = (shadow_count > 0) ? shadow_count - 1 : 0;
                5:       count_pick = $urandom_range(DEPTH);
                default: count_pick = $urandom_range(8, 1);
            endcase
            // Filling bursts only nibble at the head so the buffer can get full.
            if (mode == 0) begin
                count_pick = $urandom_range(2);
            end
            drop_cnt = COUNT_W'(count_pick);

            if (shadow_count > 0 && $urandom_range(3) != 0) begin
                peek_off = BYTE_W'($urandom_range(shadow_count - 1));
            end else begin
                peek_off = BYTE_W'($urandom_range(255));
            end
            // Never read an entry that has not been written yet.
            if (func == FUNC_PEEK && !shadow_written[(shadow_head + peek_off) % DEPTH]) begin
                func = FUNC_WRITE;
            end

            send_word(func, 8'($urandom), drop_cnt, peek_off);
        end
        wait_for_results();
    endtask

    // The receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker. The word is captured at the edge that accepts it and
    // compared a moment later, once the sender has recorded any expectation
    // from the same edge.
    always @(posedge aclk) begin : result_checker
        ring_result_t seen;
        ring_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen.peek_byte     = m_peek_byte;
            seen.fill_level    = m_fill_level;
            seen.is_full       = m_is_full;
            seen.write_dropped = m_write_dropped;
            #1;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, seen);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("peek_byte", 16'(want.peek_byte), 16'(seen.peek_byte));
                check_field("fill_level", 16'(want.fill_level), 16'(seen.fill_level));
                check_field("is_full", 16'(want.is_full), 16'(seen.is_full));
                check_field("write_dropped", 16'(want.write_dropped),
                            16'(seen.write_dropped));
            end
        end
    end

    // Watchdog: a run in which no word moves on either side for too long is hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("byte_ring_buffer_peek_drop_unit regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_ops();
        test_full_buffer();
        // Sender idles a third of the time while the receiver mostly stalls,
        // then the roles swap, then both run flat out.
        test_random_traffic(440, 33, 74);
        test_random_traffic(440, 74, 33);
        test_random_traffic(430, 0, 0);

        // Let any stray extra word surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("byte_ring_buffer_peek_drop_unit regression: pass");
        end else begin
            $display("byte_ring_buffer_peek_drop_unit regression: fail");
        end
        $finish;
    end

endmodule
